[hdl/fsss_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_pkg
// Types, codes and the breeze speed table shared by the fan and swing
// sequencer.
// ----------------------------------------------------------------------------
package fsss_pkg;

  localparam int BREEZE_STEPS_DEF = 28;
  localparam int IN_TDATA_W       = 40;
  localparam int OUT_TDATA_W      = 24;
  localparam int CFG_ADDR_W       = 3;

  localparam logic [1:0] MS_NONE    = 2'd0;
  localparam logic [1:0] MS_WORKING = 2'd1;
  localparam logic [1:0] MS_OTHER   = 2'd2;

  localparam logic [1:0] MODE_SLEEP  = 2'd0;
  localparam logic [1:0] MODE_NATURE = 2'd1;
  localparam logic [1:0] MODE_MAX    = 2'd2;
  localparam logic [1:0] MODE_NORMAL = 2'd3;

  localparam logic [1:0] CMD_RUN    = 2'd0;
  localparam logic [1:0] CMD_RESET  = 2'd1;
  localparam logic [1:0] CMD_MIDDLE = 2'd2;

  localparam logic REG_FIRST_RUN = 1'b0;
  localparam logic REG_DWELL     = 1'b1;

  localparam logic [7:0] FIRST_RUN_RESET = 8'd30;
  localparam logic [3:0] DWELL_RESET     = 4'd3;

  localparam logic [2:0] SPEED_OFF   = 3'd0;
  localparam logic [2:0] SPEED_FLOOR = 3'd3;
  localparam logic [2:0] SPEED_MAX   = 3'd7;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic [4:0] vert_motor_status;
    logic [4:0] horiz_motor_status;
    logic [1:0] vert_span_select;
    logic [1:0] horiz_span_select;
    logic       vert_swing_on;
    logic       horiz_swing_on;
    logic [2:0] manual_speed;
    logic       second_tick;
    logic [7:0] sleep_half_hours;
    logic [1:0] fan_mode;
    logic       start_timer_pending;
    logic [1:0] machine_state;
  } fsss_in_t;

  // Per-axis result after this tick's update
  typedef struct packed {
    logic [2:0] span_code;
    logic       enable;
    logic [3:0] roll;
    logic [1:0] command;
  } axis_res_t;

  typedef struct packed {
    axis_res_t  vert;
    axis_res_t  horiz;
    logic [2:0] fan_speed;
  } fsss_out_t;

  function automatic logic [2:0] breeze_level(input logic [4:0] step);
    logic [2:0] lvl;
    unique case (step)
      5'd0, 5'd1, 5'd9, 5'd10, 5'd11, 5'd12, 5'd21, 5'd22: lvl = 3'd7;
      5'd4, 5'd5, 5'd15, 5'd16, 5'd19, 5'd20:               lvl = 3'd3;
      5'd6, 5'd23:                                          lvl = 3'd1;
      default:                                              lvl = 3'd5;
    endcase
    return lvl;
  endfunction

endpackage
`default_nettype wire

[hdl/fan_speed_and_swing_sequencer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fan_speed_and_swing_sequencer_unit
// Per-tick fan speed selection and two-axis swing handshake.
// ----------------------------------------------------------------------------
// One input transfer per 100 ms tick yields one result transfer. The whole
// update is a single pass of shallow logic from the held state and the input
// word into the state registers and the result register, so a transfer is
// taken every cycle and its result appears in the next cycle; the result
// register is reloaded in the same cycle that its contents are taken, and the
// input stalls only while a result waits with out_tready low. Configuration,
// at APB byte addresses 0 (first_run_ticks) and 4 (nature_dwell_seconds), is
// to be written only while the unit is idle; the block does not enforce this.
module fan_speed_and_swing_sequencer_unit
  import fsss_pkg::*;
#(
  parameter int BREEZE_STEPS = BREEZE_STEPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  // machine_state[1:0], start_timer_pending[2], fan_mode[4:3],
  // sleep_half_hours[12:5], second_tick[13], manual_speed[16:14],
  // horiz_swing_on[17], vert_swing_on[18], horiz_span_select[20:19],
  // vert_span_select[22:21], horiz_motor_status[27:23],
  // vert_motor_status[32:28], zero[39:33]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  // fan_speed[2:0], horiz_command[4:3], horiz_roll[8:5], horiz_enable[9],
  // horiz_span_code[12:10], vert_command[14:13], vert_roll[18:15],
  // vert_enable[19], vert_span_code[22:20], zero[23]
  output      logic [OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [31:0]            cfg_pwdata,
  output      logic [31:0]            cfg_prdata,
  output      logic                   cfg_pready
);

  fsss_in_t  item;
  fsss_out_t res;
  logic      fire;
  logic      working;

  logic [7:0] first_run_r;
  logic [3:0] dwell_r;

  logic [3:0] bcount_r, bcount_nxt;
  logic [4:0] bstep_r, bstep_nxt;
  logic [7:0] run_r, run_nxt;
  logic [2:0] speed_r, speed_nxt;

  logic       out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [4:0] sec_sum;
  logic [5:0] step_sum;

  assign item      = in_tdata[$bits(fsss_in_t)-1:0];
  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;
  assign working   = (item.machine_state == MS_WORKING) && !item.start_timer_pending;

  // configuration registers
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_run_r <= FIRST_RUN_RESET;
      dwell_r     <= DWELL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_FIRST_RUN: first_run_r <= cfg_pwdata[7:0];
        REG_DWELL:     dwell_r     <= cfg_pwdata[3:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_FIRST_RUN: cfg_prdata = {24'd0, first_run_r};
      REG_DWELL:     cfg_prdata = {28'd0, dwell_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // fan speed selection
  assign sec_sum  = {1'b0, bcount_r} + 5'd1;
  assign step_sum = {1'b0, bstep_r} + 6'd1;

  always_comb begin
    bcount_nxt = bcount_r;
    bstep_nxt  = bstep_r;
    run_nxt    = run_r;
    speed_nxt  = speed_r;
    if (working) begin
      unique case (item.fan_mode)
        MODE_SLEEP: begin
          priority if (item.sleep_half_hours == 8'd0) speed_nxt = 3'd3;
          else if (item.sleep_half_hours <= 8'd3)     speed_nxt = 3'd2;
          else                                        speed_nxt = 3'd1;
        end
        MODE_NATURE: begin
          if (item.second_tick) begin
            if (sec_sum >= {1'b0, dwell_r}) begin
              bcount_nxt = 4'd0;
              bstep_nxt  = (step_sum >= 6'(BREEZE_STEPS)) ? 5'd0 : step_sum[4:0];
            end else begin
              bcount_nxt = sec_sum[3:0];
            end
          end
          speed_nxt = breeze_level(bstep_nxt);
        end
        MODE_MAX: speed_nxt = SPEED_MAX;
        MODE_NORMAL: begin
          // hold at least the floor level during the first-run window
          if (run_r < first_run_r) begin
            if (speed_r <= SPEED_FLOOR) speed_nxt = SPEED_FLOOR;
          end else begin
            speed_nxt = item.manual_speed;
          end
        end
        default: ;
      endcase
      if (run_r != 8'hff) run_nxt = run_r + 8'd1;
    end else begin
      speed_nxt  = SPEED_OFF;
      run_nxt    = 8'd0;
      bcount_nxt = 4'd0;
      bstep_nxt  = 5'd0;
    end
    if (item.fan_mode != MODE_NATURE) begin
      bcount_nxt = 4'd0;
      bstep_nxt  = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= 4'd0;
      bstep_r  <= 5'd0;
      run_r    <= 8'd0;
      speed_r  <= SPEED_OFF;
    end else if (fire) begin
      bcount_r <= bcount_nxt;
      bstep_r  <= bstep_nxt;
      run_r    <= run_nxt;
      speed_r  <= speed_nxt;
    end
  end

  fsss_axis u_horiz (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (fire),
    .active      (working && item.horiz_swing_on),
    .mstate_none (item.machine_state == MS_NONE),
    .status      (item.horiz_motor_status),
    .span_sel    (item.horiz_span_select),
    .res         (res.horiz)
  );

  fsss_axis u_vert (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (fire),
    .active      (working && item.vert_swing_on),
    .mstate_none (item.machine_state == MS_NONE),
    .status      (item.vert_motor_status),
    .span_sel    (item.vert_span_select),
    .res         (res.vert)
  );

  assign res.fan_speed = speed_nxt;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {{(OUT_TDATA_W-$bits(fsss_out_t)){1'b0}}, res};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

[hdl/fsss_axis.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_axis
// One swing axis: roll-code reset handshake with the motor, command and span.
// ----------------------------------------------------------------------------
module fsss_axis
  import fsss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       advance,
  input  wire logic       active,
  input  wire logic       mstate_none,
  input  wire logic [4:0] status,
  input  wire logic [1:0] span_sel,
  output axis_res_t       res
);

  logic [7:0] req_r, req_nxt;
  logic [7:0] srv_r, srv_nxt;
  logic [3:0] roll_r, roll_nxt;
  logic [1:0] cmd_r, cmd_nxt;
  logic [2:0] span_r, span_nxt;

  logic       done;
  logic [3:0] ack;

  assign done = status[4];
  assign ack  = status[3:0];

  always_comb begin
    req_nxt  = req_r;
    srv_nxt  = srv_r;
    roll_nxt = roll_r;
    cmd_nxt  = cmd_r;
    span_nxt = span_r;
    if (active) begin
      priority if (srv_r != req_r) begin
        // new reset request: bump the roll code and park the span
        srv_nxt  = req_r;
        cmd_nxt  = CMD_RESET;
        roll_nxt = roll_r + 4'd1;
        span_nxt = 3'd0;
      end else if (done && ack == roll_r) begin
        span_nxt = {1'b0, span_sel} + 3'd1;
        cmd_nxt  = CMD_RUN;
      end else begin
        // hold command and span until the motor finishes its reset
      end
    end else begin
      if (done && mstate_none) begin
        cmd_nxt = CMD_MIDDLE;
      end
      if (roll_r != ack) begin
        req_nxt = req_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r  <= 8'd0;
      srv_r  <= 8'hff;
      roll_r <= 4'd0;
      cmd_r  <= CMD_RUN;
      span_r <= 3'd0;
    end else if (advance) begin
      req_r  <= req_nxt;
      srv_r  <= srv_nxt;
      roll_r <= roll_nxt;
      cmd_r  <= cmd_nxt;
      span_r <= span_nxt;
    end
  end

  assign res.command   = cmd_nxt;
  assign res.roll      = roll_nxt;
  assign res.enable    = active;
  assign res.span_code = span_nxt;

endmodule
`default_nettype wire

[hdl/fsss_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsss_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module fsss_checker
  import fsss_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an empty result register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no result pending");

  // not working: fan off and both drives disabled
  a_idle_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tdata[1:0] != MS_WORKING || in_tdata[2])
    |=> out_tvalid && out_tdata[2:0] == SPEED_OFF && !out_tdata[9] && !out_tdata[19])
    else $error("fan or swing driven while not working");

  // working in maximum mode gives the top level
  a_max_speed: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tdata[1:0] == MS_WORKING && !in_tdata[2] && in_tdata[4:3] == MODE_MAX
    |=> out_tvalid && out_tdata[2:0] == SPEED_MAX)
    else $error("maximum mode did not give top speed");

endmodule

bind fan_speed_and_swing_sequencer_unit fsss_checker u_fsss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fan speed and swing sequencer. Ticks are sent
// as stream transfers in bursts with random gaps, while the result side
// stalls on its own pattern. A bit-true predictor of the speed selection and
// of both swing axes runs alongside, and each result transfer is compared
// field by field with the oldest prediction. Directed ticks cover the field
// extremes and the swing reset handshake. Random sessions then follow across
// several register settings, run by run with the motors mostly answering.
// ----------------------------------------------------------------------------
module tb_top;
  import fsss_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_TAIL  = 8;

  // breeze speed per table step, step 0 in the lowest bits
  localparam logic [31:0][2:0] BREEZE_LEVELS = {
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd1, 3'd7, 3'd7, 3'd3, 3'd3, 3'd5, 3'd5, 3'd3,
    3'd3, 3'd5, 3'd5, 3'd7, 3'd7, 3'd7, 3'd7, 3'd5,
    3'd5, 3'd1, 3'd3, 3'd3, 3'd5, 3'd5, 3'd7, 3'd7
  };

  typedef struct packed {
    logic [7:0] request_cnt;
    logic [7:0] served_cnt;
    logic [3:0] roll;
    logic [1:0] command;
    logic [2:0] span_code;
  } swing_axis_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [31:0]            cfg_pwdata  = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  // predictor state
  logic [7:0]  first_run_limit;
  logic [3:0]  dwell_secs;
  logic [3:0]  breeze_secs;
  logic [4:0]  breeze_idx;
  logic [7:0]  run_ticks;
  logic [2:0]  fan_level;
  swing_axis_t horiz_axis;
  swing_axis_t vert_axis;

  fsss_out_t tick_results_due[$];
  int        mismatches  = 0;
  int        clk_cycles  = 0;
  int        burst_left  = 0;
  logic      gaps_enabled = 1'b1;

  fan_speed_and_swing_sequencer_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    clk_cycles <= clk_cycles + 1;
    if (clk_cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: ready always, mostly, half the time, or in long stalls
  always @(posedge clk) begin
    case (clk_cycles[9:8])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= (clk_cycles[3:0] < 4'd12);
    endcase
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    fsss_out_t want;
    fsss_out_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(fsss_out_t)-1:0];
      if (tick_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
      end else begin
        want = tick_results_due.pop_front();
        check_field("fan_speed", 32'(want.fan_speed), 32'(got.fan_speed));
        check_field("horiz_command", 32'(want.horiz.command), 32'(got.horiz.command));
        check_field("horiz_roll", 32'(want.horiz.roll), 32'(got.horiz.roll));
        check_field("horiz_enable", 32'(want.horiz.enable), 32'(got.horiz.enable));
        check_field("horiz_span_code", 32'(want.horiz.span_code),
                    32'(got.horiz.span_code));
        check_field("vert_command", 32'(want.vert.command), 32'(got.vert.command));
        check_field("vert_roll", 32'(want.vert.roll), 32'(got.vert.roll));
        check_field("vert_enable", 32'(want.vert.enable), 32'(got.vert.enable));
        check_field("vert_span_code", 32'(want.vert.span_code),
                    32'(got.vert.span_code));
      end
    end
  end

  function automatic logic step_swing_axis(inout swing_axis_t ax, input logic active,
                                           input logic [4:0] status,
                                           input logic [1:0] span_sel,
                                           input logic [1:0] mstate);
    if (active) begin
      if (ax.served_cnt != ax.request_cnt) begin
        ax.served_cnt = ax.request_cnt;
        ax.command    = CMD_RESET;
        ax.roll       = ax.roll + 4'd1;
        ax.span_code  = 3'd0;
      end else if (status[4] && status[3:0] == ax.roll) begin
        ax.span_code = {1'b0, span_sel} + 3'd1;
        ax.command   = CMD_RUN;
      end
      return 1'b1;
    end
    if (status[4] && mstate == MS_NONE)
      ax.command = CMD_MIDDLE;
    // motor disagrees on the roll code: queue another reset
    if (ax.roll != status[3:0])
      ax.request_cnt = ax.request_cnt + 8'd1;
    return 1'b0;
  endfunction

  task automatic compute_tick_outputs(input fsss_in_t it, output fsss_out_t res);
    logic working;
    int   nxt;
    working = (it.machine_state == MS_WORKING) && !it.start_timer_pending;
    if (working) begin
      case (it.fan_mode)
        MODE_SLEEP: begin
          if (it.sleep_half_hours == 8'd0)
            fan_level = 3'd3;
          else if (it.sleep_half_hours <= 8'd3)
            fan_level = 3'd2;
          else
            fan_level = 3'd1;
        end
        MODE_NATURE: begin
          if (it.second_tick) begin
            nxt = breeze_secs + 1;
            if (nxt >= dwell_secs) begin
              breeze_secs = 4'd0;
              nxt = breeze_idx + 1;
              breeze_idx = (nxt >= BREEZE_STEPS_DEF) ? 5'd0 : nxt[4:0];
            end else begin
              breeze_secs = nxt[3:0];
            end
          end
          fan_level = BREEZE_LEVELS[breeze_idx];
        end
        MODE_MAX: fan_level = SPEED_MAX;
        default: begin
          // hold a higher level during the first run, raise a lower one
          if (run_ticks < first_run_limit) begin
            if (fan_level <= SPEED_FLOOR)
              fan_level = SPEED_FLOOR;
          end else begin
            fan_level = it.manual_speed;
          end
        end
      endcase
      if (run_ticks != 8'hff)
        run_ticks = run_ticks + 8'd1;
    end else begin
      fan_level   = SPEED_OFF;
      run_ticks   = 8'd0;
      breeze_secs = 4'd0;
      breeze_idx  = 5'd0;
    end
    if (it.fan_mode != MODE_NATURE) begin
      breeze_secs = 4'd0;
      breeze_idx  = 5'd0;
    end
    res = '0;
    res.fan_speed    = fan_level;
    res.horiz.enable = step_swing_axis(horiz_axis, working && it.horiz_swing_on,
                                       it.horiz_motor_status, it.horiz_span_select,
                                       it.machine_state);
    res.vert.enable  = step_swing_axis(vert_axis, working && it.vert_swing_on,
                                       it.vert_motor_status, it.vert_span_select,
                                       it.machine_state);
    res.horiz.command   = horiz_axis.command;
    res.horiz.roll      = horiz_axis.roll;
    res.horiz.span_code = horiz_axis.span_code;
    res.vert.command    = vert_axis.command;
    res.vert.roll       = vert_axis.roll;
    res.vert.span_code  = vert_axis.span_code;
  endtask

  task automatic send_tick(input fsss_in_t it);
    fsss_out_t res;
    int        gap;
    if (gaps_enabled) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 30);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-$bits(fsss_in_t)){1'b0}}, it};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    compute_tick_outputs(it, res);
    tick_results_due.push_back(res);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    // go idle before the next access
    @(posedge clk);
  endtask

  task automatic program_register(input logic idx, input logic [31:0] value);
    logic [31:0] rdata;
    logic [31:0] mask;
    logic [CFG_ADDR_W-1:0] addr;
    addr = {idx, 2'b00};
    mask = (idx == REG_FIRST_RUN) ? 32'hff : 32'hf;
    cfg_access(1'b1, addr, value, rdata);
    if (idx == REG_FIRST_RUN)
      first_run_limit = value[7:0];
    else
      dwell_secs = value[3:0];
    cfg_access(1'b0, addr, 32'd0, rdata);
    check_field("register readback", value & mask, rdata & mask);
  endtask

  task automatic apply_settings(input logic [7:0] first_run, input logic [3:0] dwell);
    drain_results();
    program_register(REG_FIRST_RUN, {24'd0, first_run});
    program_register(REG_DWELL, {28'd0, dwell});
  endtask

  function automatic fsss_in_t make_tick(
      input logic [1:0] mstate, input logic pending, input logic [1:0] mode,
      input logic [7:0] half_hours, input logic sec, input logic [2:0] manual,
      input logic h_on, input logic v_on, input logic [1:0] h_sel,
      input logic [1:0] v_sel, input logic [4:0] h_status, input logic [4:0] v_status);
    fsss_in_t it;
    it.machine_state       = mstate;
    it.start_timer_pending = pending;
    it.fan_mode            = mode;
    it.sleep_half_hours    = half_hours;
    it.second_tick         = sec;
    it.manual_speed        = manual;
    it.horiz_swing_on      = h_on;
    it.vert_swing_on       = v_on;
    it.horiz_span_select   = h_sel;
    it.vert_span_select    = v_sel;
    it.horiz_motor_status  = h_status;
    it.vert_motor_status   = v_status;
    return it;
  endfunction

  // a motor that mostly echoes the current roll code, now and then garbled
  function automatic logic [4:0] motor_reply(input swing_axis_t ax);
    case ($urandom_range(0, 7))
      0:       return 5'($urandom);
      1:       return {1'b0, ax.roll};
      2:       return {1'b1, ax.roll + 4'd1};
      default: return {1'b1, ax.roll};
    endcase
  endfunction

  task automatic test_field_extremes();
    send_tick(make_tick(MS_NONE, 1'b0, MODE_SLEEP, 8'd0, 1'b0, 3'd0, 1'b0, 1'b0,
                        2'd0, 2'd0, 5'd0, 5'd0));
    send_tick(make_tick(2'd3, 1'b1, MODE_NORMAL, 8'hff, 1'b1, 3'd7, 1'b1, 1'b1,
                        2'd3, 2'd3, 5'h1f, 5'h1f));
    send_tick(make_tick(MS_OTHER, 1'b0, MODE_MAX, 8'd5, 1'b1, 3'd5, 1'b1, 1'b1,
                        2'd1, 2'd2, 5'h10, 5'h0f));
    send_tick(make_tick(MS_WORKING, 1'b1, MODE_MAX, 8'd0, 1'b0, 3'd2, 1'b1, 1'b1,
                        2'd0, 2'd1, 5'd0, 5'd0));
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_SLEEP, 8'd0, 1'b0, 3'd0, 1'b1, 1'b1,
                        2'd0, 2'd3, 5'd0, 5'd0));
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_SLEEP, 8'd1, 1'b0, 3'd0, 1'b1, 1'b1,
                        2'd1, 2'd2, 5'h11, 5'h11));
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_SLEEP, 8'd3, 1'b0, 3'd0, 1'b1, 1'b0,
                        2'd2, 2'd1, 5'h11, 5'h01));
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_SLEEP, 8'd4, 1'b0, 3'd0, 1'b0, 1'b1,
                        2'd3, 2'd0, 5'h11, 5'h11));
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_SLEEP, 8'hff, 1'b0, 3'd0, 1'b1, 1'b1,
                        2'd0, 2'd0, 5'h11, 5'h11));
    repeat (4)
      send_tick(make_tick(MS_WORKING, 1'b0, MODE_NATURE, 8'd0, 1'b1, 3'd0, 1'b1, 1'b1,
                          2'd2, 2'd3, 5'h11, 5'h11));
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_MAX, 8'd0, 1'b0, 3'd0, 1'b1, 1'b1,
                        2'd1, 2'd1, 5'h11, 5'h11));
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_NORMAL, 8'd0, 1'b0, 3'd0, 1'b1, 1'b1,
                        2'd1, 2'd1, 5'h11, 5'h11));
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_NORMAL, 8'd0, 1'b0, 3'd7, 1'b1, 1'b1,
                        2'd1, 2'd1, 5'h11, 5'h11));
    // machine off with the motor reporting reset done: go to middle
    send_tick(make_tick(MS_NONE, 1'b0, MODE_NORMAL, 8'd0, 1'b0, 3'd7, 1'b1, 1'b1,
                        2'd1, 2'd1, 5'h11, 5'h13));
    send_tick(make_tick(MS_NONE, 1'b0, MODE_NORMAL, 8'd0, 1'b0, 3'd7, 1'b0, 1'b0,
                        2'd1, 2'd1, 5'h0a, 5'h15));
  endtask

  task automatic test_swing_handshake();
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_MAX, 8'd0, 1'b0, 3'd0, 1'b1, 1'b1,
                        2'd2, 2'd0, 5'd0, 5'd0));
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_MAX, 8'd0, 1'b0, 3'd0, 1'b1, 1'b1,
                        2'd2, 2'd0, {1'b1, horiz_axis.roll}, {1'b1, vert_axis.roll}));
    // acknowledged but reset not done: command and span hold
    send_tick(make_tick(MS_WORKING, 1'b0, MODE_MAX, 8'd0, 1'b0, 3'd0, 1'b1, 1'b1,
                        2'd3, 2'd1, {1'b0, horiz_axis.roll}, {1'b0, vert_axis.roll}));
    // walk the roll code round its full range and past the wrap
    repeat (17) begin
      send_tick(make_tick(MS_WORKING, 1'b0, MODE_MAX, 8'd0, 1'b0, 3'd0, 1'b0, 1'b0,
                          2'd0, 2'd0, {1'b1, horiz_axis.roll + 4'd3},
                          {1'b0, vert_axis.roll + 4'd1}));
      send_tick(make_tick(MS_WORKING, 1'b0, MODE_MAX, 8'd0, 1'b0, 3'd0, 1'b1, 1'b1,
                          2'd1, 2'd3, {1'b1, horiz_axis.roll}, 5'd0));
      send_tick(make_tick(MS_WORKING, 1'b0, MODE_MAX, 8'd0, 1'b0, 3'd0, 1'b1, 1'b1,
                          2'd1, 2'd3, {1'b1, horiz_axis.roll}, {1'b1, vert_axis.roll}));
    end
  endtask

  task automatic test_run_tick_saturation();
    apply_settings(8'hff, DWELL_RESET);
    gaps_enabled = 1'b1;
    send_tick(make_tick(MS_NONE, 1'b0, MODE_NORMAL, 8'd0, 1'b0, 3'd1, 1'b0, 1'b0,
                        2'd0, 2'd0, 5'd0, 5'd0));
    repeat (300)
      send_tick(make_tick(MS_WORKING, 1'b0, MODE_NORMAL, 8'd0, 1'b0, 3'd1, 1'b0, 1'b0,
                          2'd0, 2'd0, {1'b0, horiz_axis.roll}, {1'b0, vert_axis.roll}));
  endtask

  task automatic run_session(input int n_items, input logic noisy);
    fsss_in_t    it;
    logic [63:0] raw;
    logic [1:0]  mode;
    logic [2:0]  manual;
    logic [7:0]  half_hours;
    int          sec_rate;
    logic        h_on;
    logic        v_on;
    logic [1:0]  h_sel;
    logic [1:0]  v_sel;
    mode     = 2'($urandom_range(0, 3));
    manual   = 3'($urandom_range(0, 7));
    sec_rate = $urandom_range(1, 4);
    h_on     = ($urandom_range(0, 3) != 0);
    v_on     = ($urandom_range(0, 3) != 0);
    h_sel    = 2'($urandom_range(0, 3));
    v_sel    = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       half_hours = 8'd0;
      1:       half_hours = 8'd1;
      2:       half_hours = 8'd3;
      3:       half_hours = 8'd4;
      default: half_hours = 8'($urandom_range(0, 255));
    endcase
    for (int k = 0; k < n_items; k++) begin
      if (noisy) begin
        raw = {$urandom, $urandom};
        it  = raw[$bits(fsss_in_t)-1:0];
      end else begin
        if ($urandom_range(0, 29) == 0) h_on = ~h_on;
        if ($urandom_range(0, 29) == 0) v_on = ~v_on;
        if ($urandom_range(0, 39) == 0) half_hours = half_hours + 8'd1;
        it = make_tick(($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : MS_WORKING,
                       ($urandom_range(0, 24) == 0),
                       ($urandom_range(0, 29) == 0) ? 2'($urandom_range(0, 3)) : mode,
                       half_hours, ($urandom_range(1, sec_rate) == 1),
                       ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : manual,
                       h_on, v_on, h_sel, v_sel,
                       motor_reply(horiz_axis), motor_reply(vert_axis));
      end
      send_tick(it);
    end
  endtask

  task automatic test_random_sessions(input int per_phase);
    int   sent;
    int   len;
    logic [7:0] first_run;
    logic [3:0] dwell;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin first_run = FIRST_RUN_RESET; dwell = DWELL_RESET; end
        1: begin first_run = 8'd0;  dwell = 4'd1;  end
        2: begin first_run = 8'hff; dwell = 4'd15; end
        // zero dwell: every second tick advances the breeze table
        3: begin first_run = 8'($urandom_range(0, 255)); dwell = 4'd0; end
        default: begin
          first_run = 8'($urandom_range(0, 255));
          dwell     = 4'($urandom_range(1, 15));
        end
      endcase
      apply_settings(first_run, dwell);
      gaps_enabled = (phase != 1);
      sent = 0;
      while (sent < per_phase) begin
        len = $urandom_range(1, 60);
        run_session(len, ($urandom_range(0, 9) == 0));
        sent += len;
      end
    end
  endtask

  initial begin
    first_run_limit = FIRST_RUN_RESET;
    dwell_secs      = DWELL_RESET;
    breeze_secs     = 4'd0;
    breeze_idx      = 5'd0;
    run_ticks       = 8'd0;
    fan_level       = SPEED_OFF;
    horiz_axis      = '{request_cnt: 8'd0, served_cnt: 8'hff, roll: 4'd0,
                        command: CMD_RUN, span_code: 3'd0};
    vert_axis       = horiz_axis;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_swing_handshake();
    test_run_tick_saturation();
    test_random_sessions(200);

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && tick_results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
